// ===== design/cmc_pkg.sv =====
// shared types, register codes and arithmetic helpers for the cooling mode controller
package cmc_pkg;

  // fixed point temperature format
  localparam int TEMP_FRACTION_BITS = 4;
  localparam int TEMP_W = 12;
  localparam int SP_W   = 6;
  localparam int HUM_W  = 7;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SHOWN_W = 8;

  // width that holds temperature minus shifted setpoint without overflow
  localparam int DIFF_W = ((TEMP_W > SP_W + TEMP_FRACTION_BITS + 1) ?
                           TEMP_W : SP_W + TEMP_FRACTION_BITS + 1) + 1;

  // register reset values
  localparam logic [SP_W-1:0]   SP_INIT_RST  = SP_W'(24);
  localparam logic [SP_W-1:0]   SP_LOW_RST   = SP_W'(16);
  localparam logic [SP_W-1:0]   SP_HIGH_RST  = SP_W'(30);
  localparam logic [HUM_W-1:0]  HUM_RISE_RST = HUM_W'(10);
  localparam logic [TIME_W-1:0] PAUSE_RST    = TIME_W'(120000);
  localparam logic [TIME_W-1:0] RECOVER_RST  = TIME_W'(300000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SP_INIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SP_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SP_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_RISE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER  = 3'd5;

  // operating modes
  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_COOLING  = 3'd2,
    MODE_MANUAL   = 3'd3,
    MODE_SUSPECT  = 3'd4,
    MODE_PAUSED   = 3'd5,
    MODE_RECOVERY = 3'd6
  } mode_t;

  // button bit positions
  localparam int EV_POWER  = 0;
  localparam int EV_UP     = 1;
  localparam int EV_DOWN   = 2;
  localparam int EV_MANUAL = 3;

  // one input word
  typedef struct packed {
    logic [3:0]        user_event_bits;
    logic              sensor_present;
    logic              sensor_valid;
    logic              win_contact;
    logic [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]  humidity;
    logic [TIME_W-1:0] time_now;
  } item_t;

  // one result word
  typedef struct packed {
    mode_t              mode;
    logic [SHOWN_W-1:0] shown_temperature;
    logic [SP_W-1:0]    shown_setpoint;
    logic               temperature_known;
    logic [1:0]         fan_speed;
  } res_t;

  // live configuration seen by the step logic
  typedef struct packed {
    logic [SP_W-1:0]   sp_low;
    logic [SP_W-1:0]   sp_high;
    logic [HUM_W-1:0]  hum_rise;
    logic [TIME_W-1:0] pause_time;
    logic [TIME_W-1:0] recover_time;
  } cfg_t;

  // fan level from temperature above setpoint
  function automatic logic [1:0] level_of(logic signed [TEMP_W-1:0] t,
                                          logic [SP_W-1:0] sp, logic manual);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] one;
    logic [1:0] lvl;
    one = DIFF_W'(1) << TEMP_FRACTION_BITS;
    d   = DIFF_W'(t) - (DIFF_W'(sp) << TEMP_FRACTION_BITS);
    if ((!manual && d <= one) || (manual && d <= DIFF_W'(0)))
      lvl = 2'd0;
    else if (d <= (one <<< 1))
      lvl = 2'd1;
    else if (d <= (one <<< 2))
      lvl = 2'd2;
    else
      lvl = 2'd3;
    return lvl;
  endfunction

  // round half away from zero to whole degrees, saturated to 8 bits
  function automatic logic [SHOWN_W-1:0] round_whole(logic signed [TEMP_W-1:0] t);
    logic             neg;
    logic [TEMP_W-1:0] mag;
    logic [TEMP_W:0]   sum;
    logic [TEMP_W:0]   r;
    logic [SHOWN_W-1:0] res;
    neg = t[TEMP_W-1];
    mag = neg ? TEMP_W'(-t) : TEMP_W'(t);
    sum = {1'b0, mag} + ((TEMP_W + 1)'(1 << TEMP_FRACTION_BITS) >> 1);
    r   = sum >> TEMP_FRACTION_BITS;
    if (!neg)
      res = (r > (TEMP_W + 1)'(127)) ? SHOWN_W'(127) : r[SHOWN_W-1:0];
    else
      res = (r > (TEMP_W + 1)'(128)) ? SHOWN_W'(128) : SHOWN_W'(-r);
    return res;
  endfunction

endpackage

// ===== design/cmc_state.sv =====
// controller state registers and the combinational step update
module cmc_state (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  cmc_pkg::item_t item,
  input  cmc_pkg::cfg_t  cfg,
  output cmc_pkg::res_t  res
);
  import cmc_pkg::*;

  logic                     powered_r, powered_nxt;
  logic                     manual_r, manual_nxt;
  logic                     pause_r, pause_nxt;
  logic                     win_seen_r, win_seen_nxt;
  logic                     stored_r, stored_nxt;
  logic [SP_W-1:0]          sp_r, sp_nxt;
  logic [TEMP_W-1:0]        temp_r, temp_nxt;
  logic [HUM_W-1:0]         hum_r, hum_nxt;
  logic [HUM_W-1:0]         hum_open_r, hum_open_nxt;
  logic [TIME_W-1:0]        opened_r, opened_nxt;
  logic [TIME_W-1:0]        recov_r, recov_nxt;
  mode_t                    mode_r, mode_nxt;

  logic                     present, valid, win;
  logic [SP_W-1:0]          sp_up;
  logic [TIME_W-1:0]        open_ms, recov_ms;
  logic signed [HUM_W+1:0]  hum_diff;
  logic                     rise;
  logic [1:0]               auto_lvl, man_lvl;

  assign present = item.sensor_present;
  assign valid   = item.sensor_valid;
  assign win     = item.win_contact;

  // next state for one step
  always_comb begin
    powered_nxt  = powered_r;
    manual_nxt   = manual_r;
    pause_nxt    = pause_r;
    win_seen_nxt = win_seen_r;
    stored_nxt   = stored_r;
    sp_nxt       = sp_r;
    temp_nxt     = temp_r;
    hum_nxt      = hum_r;
    hum_open_nxt = hum_open_r;
    opened_nxt   = opened_r;
    recov_nxt    = recov_r;
    mode_nxt     = mode_r;

    // power toggle clears the latches when switching off
    if (item.user_event_bits[EV_POWER]) begin
      powered_nxt = !powered_r;
      if (powered_r) begin
        manual_nxt   = 1'b0;
        pause_nxt    = 1'b0;
        win_seen_nxt = 1'b0;
      end
    end

    // setpoint buttons, up then down
    sp_up = (item.user_event_bits[EV_UP] && sp_r < cfg.sp_high) ? sp_r + 1'b1 : sp_r;
    sp_nxt = (item.user_event_bits[EV_DOWN] && sp_up > cfg.sp_low) ? sp_up - 1'b1 : sp_up;

    // manual toggle only while powered
    if (item.user_event_bits[EV_MANUAL] && powered_nxt) begin
      manual_nxt = !manual_nxt;
      if (manual_nxt)
        pause_nxt = 1'b0;
    end

    // capture window opening
    if (present && win && !win_seen_nxt) begin
      opened_nxt   = item.time_now;
      hum_open_nxt = stored_r ? hum_r : item.humidity;
    end

    // store valid reading
    if (present && valid) begin
      temp_nxt   = item.temperature;
      hum_nxt    = item.humidity;
      stored_nxt = 1'b1;
    end

    open_ms  = item.time_now - opened_nxt;
    recov_ms = item.time_now - recov_r;
    hum_diff = $signed({2'b00, item.humidity}) - $signed({2'b00, hum_open_nxt});
    rise     = valid && (hum_diff >= $signed({2'b00, cfg.hum_rise}));
    auto_lvl = level_of($signed(temp_nxt), sp_nxt, 1'b0);
    man_lvl  = level_of($signed(temp_nxt), sp_nxt, 1'b1);

    // mode decision
    if (!powered_nxt) begin
      mode_nxt = MODE_OFF;
    end else if (manual_nxt) begin
      mode_nxt = MODE_MANUAL;
    end else if (present && win) begin
      if (open_ms >= cfg.pause_time || rise || pause_nxt) begin
        pause_nxt = 1'b1;
        mode_nxt  = MODE_PAUSED;
      end else begin
        mode_nxt = MODE_SUSPECT;
      end
    end else if (win_seen_nxt) begin
      recov_nxt = item.time_now;
      pause_nxt = 1'b0;
      mode_nxt  = MODE_RECOVERY;
    end else if (mode_r == MODE_RECOVERY && recov_ms < cfg.recover_time) begin
      mode_nxt = MODE_RECOVERY;
    end else if (stored_nxt && auto_lvl != 2'd0) begin
      mode_nxt = MODE_COOLING;
    end else begin
      mode_nxt = MODE_IDLE;
    end

    if (present)
      win_seen_nxt = win;
  end

  // result word from the updated state
  always_comb begin
    res.mode              = mode_nxt;
    res.shown_temperature = stored_nxt ? round_whole($signed(temp_nxt)) : SHOWN_W'(0);
    res.shown_setpoint    = sp_nxt;
    res.temperature_known = stored_nxt;
    case (mode_nxt)
      MODE_COOLING: res.fan_speed = auto_lvl;
      MODE_MANUAL:  res.fan_speed = man_lvl;
      default:      res.fan_speed = 2'd0;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      powered_r  <= 1'b0;
      manual_r   <= 1'b0;
      pause_r    <= 1'b0;
      win_seen_r <= 1'b0;
      stored_r   <= 1'b0;
      sp_r       <= SP_INIT_RST;
      temp_r     <= '0;
      hum_r      <= '0;
      hum_open_r <= '0;
      opened_r   <= '0;
      recov_r    <= '0;
      mode_r     <= MODE_OFF;
    end else if (fire) begin
      powered_r  <= powered_nxt;
      manual_r   <= manual_nxt;
      pause_r    <= pause_nxt;
      win_seen_r <= win_seen_nxt;
      stored_r   <= stored_nxt;
      sp_r       <= sp_nxt;
      temp_r     <= temp_nxt;
      hum_r      <= hum_nxt;
      hum_open_r <= hum_open_nxt;
      opened_r   <= opened_nxt;
      recov_r    <= recov_nxt;
      mode_r     <= mode_nxt;
    end
  end

endmodule

// ===== design/cmc_result_reg.sv =====
// output register holding one result word until the consumer takes it
module cmc_result_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  cmc_pkg::res_t res_in,
  input  logic          out_stall,
  output logic          out_valid,
  output cmc_pkg::res_t res_out
);
  import cmc_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  // full while loaded or still stalled
  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= 1'b0;
    else
      valid_r <= valid_nxt;
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load)
      res_r <= res_in;
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ===== design/cooling_mode_controller_core.sv =====
// top level of the cooling mode controller: config registers, input register, step and result
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | buttons, sensor message, time stamp
//  out_    | output    | out_valid/out_stall| mode, shown temperature, setpoint, level
//  cfg_    | input     | cfg_we             | register index and data, write only
//
// One word per cycle while out_stall is low; each word passes through the input register,
// where the step logic updates the state, and then the result register. Synchronous
// active-low reset returns the state, configuration and valid flags to their defaults;
// the input and result payloads are not reset. A stalled result holds the input register;
// in_stall rises only when both registers are full and out_stall is high.
module cooling_mode_controller_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3:0]                   in_user_event_bits,
  input  logic                         in_sensor_present,
  input  logic                         in_sensor_valid,
  input  logic                         in_win_contact,
  input  logic signed [cmc_pkg::TEMP_W-1:0] in_temperature,
  input  logic [cmc_pkg::HUM_W-1:0]    in_humidity,
  input  logic [cmc_pkg::TIME_W-1:0]   in_time_now,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_mode,
  output logic signed [cmc_pkg::SHOWN_W-1:0] out_shown_temperature,
  output logic [cmc_pkg::SP_W-1:0]     out_shown_setpoint,
  output logic                         out_temperature_known,
  output logic [1:0]                   out_fan_speed,
  input  logic                         cfg_we,
  input  logic [cmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmc_pkg::CFG_W-1:0]    cfg_data
);
  import cmc_pkg::*;

  logic [SP_W-1:0]   cfg_sp_low_r;
  logic [SP_W-1:0]   cfg_sp_high_r;
  logic [HUM_W-1:0]  cfg_hum_rise_r;
  logic [TIME_W-1:0] cfg_pause_r;
  logic [TIME_W-1:0] cfg_recover_r;
  cfg_t              cfg;

  logic              in_full_r, in_full_nxt;
  item_t             item_r;
  logic              in_take;
  logic              advance;
  res_t              step_res;
  res_t              out_res;

  // configuration registers; writes to the initial setpoint index are ignored, the setpoint resets to SP_INIT_RST
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sp_low_r   <= SP_LOW_RST;
      cfg_sp_high_r  <= SP_HIGH_RST;
      cfg_hum_rise_r <= HUM_RISE_RST;
      cfg_pause_r    <= PAUSE_RST;
      cfg_recover_r  <= RECOVER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SP_INIT:  ;
        CFG_SP_LOW:   cfg_sp_low_r   <= cfg_data[SP_W-1:0];
        CFG_SP_HIGH:  cfg_sp_high_r  <= cfg_data[SP_W-1:0];
        CFG_HUM_RISE: cfg_hum_rise_r <= cfg_data[HUM_W-1:0];
        CFG_PAUSE:    cfg_pause_r    <= cfg_data[TIME_W-1:0];
        CFG_RECOVER:  cfg_recover_r  <= cfg_data[TIME_W-1:0];
        default:      ;
      endcase
    end
  end

  assign cfg.sp_low       = cfg_sp_low_r;
  assign cfg.sp_high      = cfg_sp_high_r;
  assign cfg.hum_rise     = cfg_hum_rise_r;
  assign cfg.pause_time   = cfg_pause_r;
  assign cfg.recover_time = cfg_recover_r;

  // handshake: the input word moves on when the result register can take it
  assign advance  = in_full_r & (~out_valid | ~out_stall);
  assign in_stall = in_full_r & ~advance;
  assign in_take  = in_valid & ~in_stall;
  assign in_full_nxt = in_take | (in_full_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n)
      in_full_r <= 1'b0;
    else
      in_full_r <= in_full_nxt;
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.user_event_bits <= in_user_event_bits;
      item_r.sensor_present  <= in_sensor_present;
      item_r.sensor_valid    <= in_sensor_valid;
      item_r.win_contact     <= in_win_contact;
      item_r.temperature     <= in_temperature;
      item_r.humidity        <= in_humidity;
      item_r.time_now        <= in_time_now;
    end
  end

  cmc_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  cmc_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_in    (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_mode              = out_res.mode;
  assign out_shown_temperature = out_res.shown_temperature;
  assign out_shown_setpoint    = out_res.shown_setpoint;
  assign out_temperature_known = out_res.temperature_known;
  assign out_fan_speed         = out_res.fan_speed;

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the cooling mode controller core
`timescale 1ns / 1ps

module testbench;
  import cmc_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  // button masks
  localparam logic [3:0] BTN_POWER  = 4'b1 << EV_POWER;
  localparam logic [3:0] BTN_UP     = 4'b1 << EV_UP;
  localparam logic [3:0] BTN_DOWN   = 4'b1 << EV_DOWN;
  localparam logic [3:0] BTN_MANUAL = 4'b1 << EV_MANUAL;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [3:0]                in_user_event_bits = '0;
  logic                      in_sensor_present = 1'b0;
  logic                      in_sensor_valid = 1'b0;
  logic                      in_win_contact = 1'b0;
  logic signed [TEMP_W-1:0]  in_temperature = '0;
  logic [HUM_W-1:0]          in_humidity = '0;
  logic [TIME_W-1:0]         in_time_now = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [2:0]                out_mode;
  logic signed [SHOWN_W-1:0] out_shown_temperature;
  logic [SP_W-1:0]           out_shown_setpoint;
  logic                      out_temperature_known;
  logic [1:0]                out_fan_speed;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;

  cooling_mode_controller_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_user_event_bits    (in_user_event_bits),
    .in_sensor_present     (in_sensor_present),
    .in_sensor_valid       (in_sensor_valid),
    .in_win_contact        (in_win_contact),
    .in_temperature        (in_temperature),
    .in_humidity           (in_humidity),
    .in_time_now           (in_time_now),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_mode              (out_mode),
    .out_shown_temperature (out_shown_temperature),
    .out_shown_setpoint    (out_shown_setpoint),
    .out_temperature_known (out_temperature_known),
    .out_fan_speed         (out_fan_speed),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // controller shadow state and register copies
  logic                     m_powered;
  logic                     m_manual;
  logic                     m_paused;
  logic                     m_win_seen;
  logic                     m_have_reading;
  logic [SP_W-1:0]          m_setpoint;
  logic signed [TEMP_W-1:0] m_temp;
  logic [HUM_W-1:0]         m_hum;
  logic [HUM_W-1:0]         m_hum_open;
  logic [TIME_W-1:0]        m_opened_at;
  logic [TIME_W-1:0]        m_recov_at;
  mode_t                    m_mode;
  logic [SP_W-1:0]          c_sp_low;
  logic [SP_W-1:0]          c_sp_high;
  logic [HUM_W-1:0]         c_rise;
  logic [TIME_W-1:0]        c_pause;
  logic [TIME_W-1:0]        c_recov;

  // words waiting to be sent and results owed by the block
  item_t pending_words[$];
  res_t  results_due[$];
  item_t cur_word = '0;
  res_t  want_word;
  logic  word_up = 1'b0;
  int    in_gap = 0;
  int    out_hold = 0;
  logic  in_calm = 1'b0;
  logic  out_calm = 1'b0;
  int    words_seen = 0;
  int    bad_words = 0;
  int    cycles = 0;

  // stimulus shaping state
  logic [TIME_W-1:0] g_time = '0;
  logic [TIME_W-1:0] g_step = 32'd100;
  logic              g_power = 1'b0;
  logic              g_win = 1'b0;
  int                g_hum = 50;
  int                g_sp = 24;
  int                g_low = 16;
  int                g_high = 30;

  // fan level from fixed point temperature above setpoint
  function automatic logic [1:0] fan_level(logic signed [TEMP_W-1:0] t,
                                           logic [SP_W-1:0] sp, logic manual);
    int d;
    d = int'(t) - int'(sp) * 16;
    if ((!manual && d <= 16) || (manual && d <= 0)) return 2'd0;
    if (d <= 32) return 2'd1;
    if (d <= 64) return 2'd2;
    return 2'd3;
  endfunction

  // whole degrees, half away from zero, saturated to a signed byte
  function automatic logic [SHOWN_W-1:0] shown_degrees(logic signed [TEMP_W-1:0] t);
    int v;
    int q;
    v = int'(t);
    q = ((v < 0 ? -v : v) + 8) >>> 4;
    if (v < 0) q = -q;
    if (q > 127) q = 127;
    if (q < -128) q = -128;
    return SHOWN_W'(q);
  endfunction

  function automatic void reset_model();
    m_powered      = 1'b0;
    m_manual       = 1'b0;
    m_paused       = 1'b0;
    m_win_seen     = 1'b0;
    m_have_reading = 1'b0;
    m_setpoint     = SP_INIT_RST;
    m_temp         = '0;
    m_hum          = '0;
    m_hum_open     = '0;
    m_opened_at    = '0;
    m_recov_at     = '0;
    m_mode         = MODE_OFF;
    c_sp_low       = SP_LOW_RST;
    c_sp_high      = SP_HIGH_RST;
    c_rise         = HUM_RISE_RST;
    c_pause        = PAUSE_RST;
    c_recov        = RECOVER_RST;
  endfunction

  // one controller step: update the shadow state and form the result word
  function automatic res_t step_controller(item_t w);
    logic [TIME_W-1:0] open_ms;
    logic [TIME_W-1:0] recov_ms;
    logic              rise;
    logic [1:0]        lvl;
    res_t              r;
    lvl = 2'd0;
    // buttons
    if (w.user_event_bits[EV_POWER]) begin
      m_powered = !m_powered;
      if (!m_powered) begin
        m_manual   = 1'b0;
        m_paused   = 1'b0;
        m_win_seen = 1'b0;
      end
    end
    if (w.user_event_bits[EV_UP] && m_setpoint < c_sp_high) m_setpoint = m_setpoint + 1'b1;
    if (w.user_event_bits[EV_DOWN] && m_setpoint > c_sp_low) m_setpoint = m_setpoint - 1'b1;
    if (w.user_event_bits[EV_MANUAL] && m_powered) begin
      m_manual = !m_manual;
      if (m_manual) m_paused = 1'b0;
    end
    // window opening and reading
    if (w.sensor_present && w.win_contact && !m_win_seen) begin
      m_opened_at = w.time_now;
      m_hum_open  = m_have_reading ? m_hum : w.humidity;
    end
    if (w.sensor_present && w.sensor_valid) begin
      m_temp         = w.temperature;
      m_hum          = w.humidity;
      m_have_reading = 1'b1;
    end
    // mode decision
    open_ms  = w.time_now - m_opened_at;
    recov_ms = w.time_now - m_recov_at;
    rise = w.sensor_valid && (int'(w.humidity) - int'(m_hum_open) >= int'(c_rise));
    if (!m_powered) begin
      m_mode = MODE_OFF;
    end else if (m_manual) begin
      m_mode = MODE_MANUAL;
    end else if (w.sensor_present && w.win_contact) begin
      if (open_ms >= c_pause || rise || m_paused) begin
        m_paused = 1'b1;
        m_mode   = MODE_PAUSED;
      end else begin
        m_mode = MODE_SUSPECT;
      end
    end else if (m_win_seen) begin
      m_recov_at = w.time_now;
      m_paused   = 1'b0;
      m_mode     = MODE_RECOVERY;
    end else if (m_mode == MODE_RECOVERY && recov_ms < c_recov) begin
      m_mode = MODE_RECOVERY;
    end else if (m_have_reading && fan_level(m_temp, m_setpoint, 1'b0) != 2'd0) begin
      m_mode = MODE_COOLING;
    end else begin
      m_mode = MODE_IDLE;
    end
    if (w.sensor_present) m_win_seen = w.win_contact;
    if (m_mode == MODE_COOLING) lvl = fan_level(m_temp, m_setpoint, 1'b0);
    else if (m_mode == MODE_MANUAL) lvl = fan_level(m_temp, m_setpoint, 1'b1);
    r.mode              = m_mode;
    r.shown_temperature = m_have_reading ? shown_degrees(m_temp) : '0;
    r.shown_setpoint    = m_setpoint;
    r.temperature_known = m_have_reading;
    r.fan_speed         = lvl;
    return r;
  endfunction

  // input driver: one word at a time with a random gap after each accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if (word_up && !in_stall) begin
        results_due.push_back(step_controller(cur_word));
        word_up = 1'b0;
        if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : int'($urandom_range(0, 8));
      end
      if (!word_up) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          word_up  = 1'b1;
        end
      end
    end
    in_valid           <= word_up;
    in_user_event_bits <= cur_word.user_event_bits;
    in_sensor_present  <= cur_word.sensor_present;
    in_sensor_valid    <= cur_word.sensor_valid;
    in_win_contact     <= cur_word.win_contact;
    in_temperature     <= cur_word.temperature;
    in_humidity        <= cur_word.humidity;
    in_time_now        <= cur_word.time_now;
  end

  // result monitor: compare against the oldest owed result, random stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) $display("word %0d: result with nothing owed", words_seen);
        end else begin
          want_word = results_due.pop_front();
          if (want_word.mode !== out_mode ||
              want_word.shown_temperature !== out_shown_temperature ||
              want_word.shown_setpoint !== out_shown_setpoint ||
              want_word.temperature_known !== out_temperature_known ||
              want_word.fan_speed !== out_fan_speed) begin
            bad_words++;
            if (bad_words <= 10)
              $display("word %0d mismatch: exp mode %0d temp %0d sp %0d known %0b lvl %0d",
                       words_seen, want_word.mode, $signed(want_word.shown_temperature),
                       want_word.shown_setpoint, want_word.temperature_known,
                       want_word.fan_speed,
                       " / got mode %0d temp %0d sp %0d known %0b lvl %0d",
                       out_mode, out_shown_temperature, out_shown_setpoint,
                       out_temperature_known, out_fan_speed);
          end
        end
        words_seen++;
        if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
        out_hold = out_calm ? 0 : int'($urandom_range(0, 8));
      end else if (out_hold > 0) begin
        out_hold--;
      end
    end
    out_stall <= (out_hold > 0);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || word_up || results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_SP_INIT:  ; // never stored; the setpoint resets to SP_INIT_RST
      CFG_SP_LOW:   c_sp_low = val[SP_W-1:0];
      CFG_SP_HIGH:  c_sp_high = val[SP_W-1:0];
      CFG_HUM_RISE: c_rise = val[HUM_W-1:0];
      CFG_PAUSE:    c_pause = val;
      CFG_RECOVER:  c_recov = val;
      default:      ;
    endcase
  endtask

  task automatic push_word(input logic [3:0] ev, input logic pres, input logic val,
                           input logic win, input int temp, input int hum,
                           input logic [TIME_W-1:0] t);
    item_t w;
    w.user_event_bits = ev;
    w.sensor_present  = pres;
    w.sensor_valid    = val;
    w.win_contact     = win;
    w.temperature     = TEMP_W'(temp);
    w.humidity        = HUM_W'(hum);
    w.time_now        = t;
    pending_words.push_back(w);
  endtask

  // mostly plausible operation: power on, window open/close spells, drifting readings
  task automatic random_word();
    item_t w;
    int    t;
    w = '0;
    if ($urandom_range(0, 99) < 8) begin
      // noise across the full field widths
      w.user_event_bits = 4'($urandom);
      w.sensor_present  = 1'($urandom);
      w.sensor_valid    = 1'($urandom);
      w.win_contact     = 1'($urandom);
      w.temperature     = TEMP_W'($urandom);
      w.humidity        = HUM_W'($urandom);
      if ($urandom_range(0, 1) == 0) g_time = $urandom;
      w.time_now = g_time;
    end else begin
      w.user_event_bits[EV_POWER]  = g_power ? ($urandom_range(0, 49) == 0)
                                             : ($urandom_range(0, 9) < 4);
      w.user_event_bits[EV_UP]     = ($urandom_range(0, 99) < 8);
      w.user_event_bits[EV_DOWN]   = ($urandom_range(0, 99) < 8);
      w.user_event_bits[EV_MANUAL] = ($urandom_range(0, 99) < 4);
      w.sensor_present = ($urandom_range(0, 99) < 80);
      w.sensor_valid   = ($urandom_range(0, 99) < 90);
      if (w.sensor_present) begin
        if (g_win ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 99) < 6))
          g_win = !g_win;
        w.win_contact = g_win;
      end else begin
        w.win_contact = 1'($urandom);
      end
      // humidity climbs while the window is open
      if (g_win) g_hum = g_hum + int'($urandom_range(0, 3));
      else g_hum = g_hum + int'($urandom_range(0, 2)) - 1;
      if (g_hum > 100) g_hum = 100;
      if (g_hum < 20) g_hum = 20;
      if (!g_win && g_hum > 80) g_hum = 80;
      w.humidity = HUM_W'(g_hum);
      if ($urandom_range(0, 19) == 0) t = int'($urandom_range(0, 4095)) - 2048;
      else t = g_sp * 16 + int'($urandom_range(0, 112)) - 32;
      w.temperature = TEMP_W'(t);
      if ($urandom_range(0, 49) == 0) g_time = $urandom;
      else g_time = g_time + $urandom_range(0, g_step);
      w.time_now = g_time;
    end
    g_power = g_power ^ w.user_event_bits[EV_POWER];
    if (w.user_event_bits[EV_UP] && g_sp < g_high) g_sp++;
    if (w.user_event_bits[EV_DOWN] && g_sp > g_low) g_sp--;
    pending_words.push_back(w);
  endtask

  task automatic run_phase(input logic [SP_W-1:0] sp_init, input logic [SP_W-1:0] sp_low,
                           input logic [SP_W-1:0] sp_high, input logic [HUM_W-1:0] rise,
                           input logic [TIME_W-1:0] pause, input logic [TIME_W-1:0] recov,
                           input logic [TIME_W-1:0] step, input int count);
    wait_drained();
    write_reg(CFG_SP_INIT, CFG_W'(sp_init));
    write_reg(CFG_SP_LOW, CFG_W'(sp_low));
    write_reg(CFG_SP_HIGH, CFG_W'(sp_high));
    write_reg(CFG_HUM_RISE, CFG_W'(rise));
    write_reg(CFG_PAUSE, pause);
    write_reg(CFG_RECOVER, recov);
    @(posedge clk);
    cfg_we <= 1'b0;
    g_low  = int'(sp_low);
    g_high = int'(sp_high);
    g_step = step;
    repeat (count) random_word();
  endtask

  // stimulus and verdict
  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, buttons while off, window pause and recovery paths
    push_word(4'b0, 0, 0, 0, 0, 0, 32'd0);
    push_word(BTN_UP, 0, 0, 0, 0, 0, 32'd1);
    push_word(BTN_DOWN | BTN_MANUAL, 0, 0, 0, 0, 0, 32'd2);
    push_word(4'b0, 1, 1, 0, 2047, 127, 32'd3);
    push_word(4'b0, 1, 1, 0, -2048, 0, 32'd4);
    push_word(4'b0, 1, 1, 0, -8, 50, 32'd5);
    push_word(4'b0, 1, 0, 0, 100, 90, 32'd6);
    // power on two and a half degrees above the setpoint
    push_word(BTN_POWER, 1, 1, 0, 424, 50, 32'd10);
    push_word(4'b0, 0, 0, 1, 0, 0, 32'd20);
    // window opens, humidity climbs to the limit, pause holds until close
    push_word(4'b0, 1, 1, 1, 424, 52, 32'd1000);
    push_word(4'b0, 1, 1, 1, 424, 60, 32'd2000);
    push_word(4'b0, 1, 1, 1, 424, 50, 32'd3000);
    push_word(4'b0, 1, 1, 0, 424, 50, 32'd4000);
    push_word(4'b0, 1, 1, 0, 424, 50, 32'd200000);
    push_word(4'b0, 1, 1, 0, 424, 50, 32'd304000);
    // invalid message opens the window, pause by elapsed time
    push_word(4'b0, 1, 0, 1, 424, 50, 32'd310000);
    push_word(4'b0, 1, 1, 1, 424, 50, 32'd430000);
    // manual clears the pause, level at and just above setpoint
    push_word(BTN_MANUAL, 1, 1, 1, 384, 50, 32'd430001);
    push_word(4'b0, 1, 1, 1, 385, 50, 32'd430002);
    push_word(BTN_MANUAL, 1, 1, 0, 200, 50, 32'd430003);
    push_word(BTN_POWER, 0, 0, 0, 0, 0, 32'd430004);
    push_word(BTN_POWER | BTN_MANUAL, 0, 0, 0, 0, 0, 32'd430005);
    push_word(4'hF, 0, 0, 0, 0, 0, 32'd430006);
    g_time = 32'd430006;

    // register settings from one extreme to the other, then random ones
    run_phase(6'd0, 6'd0, 6'd63, 7'd0, 32'd0, 32'd0, 32'd300, 100);
    run_phase(6'd63, 6'd63, 6'd0, 7'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0100_0000, 100);
    run_phase(6'd24, 6'd20, 6'd22, 7'd10, 32'd120000, 32'd300000, 32'd40000, 100);
    g_time = 32'hFFFF_C000;
    run_phase(6'($urandom), 6'd16, 6'd30, 7'd8, 32'd2000, 32'd3000, 32'd400, 100);
    repeat (3)
      run_phase(6'($urandom), 6'($urandom_range(0, 30)), 6'($urandom_range(20, 63)),
                7'($urandom_range(0, 30)), $urandom_range(0, 5000),
                $urandom_range(0, 5000), $urandom_range(50, 1000), 100);

    wait_drained();
    repeat (4) @(posedge clk);
    if (bad_words == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
